### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers included by the checker file rdi_checker.sv
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RDI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RDI_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/rdi_pkg.sv
// ----------------------------------------------------------------------------
// rdi_pkg
// types and constants of the ray / disc intersection pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package rdi_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int DIV_STEPS = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd6;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
		logic signed [31:0] t_low;
		logic signed [31:0] t_high;
	} in_item_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] hit_t;
		logic signed [31:0] hit_x;
		logic signed [31:0] hit_y;
		logic signed [31:0] hit_z;
	} out_item_t;

endpackage

`default_nettype wire

### hw/rtl/ray_disc_intersection.sv
// an accepted input passes through stages s1 to s4, the divider stages and s6 to s12 to out_valid
// throughput: one ray per cycle; the whole pipeline holds while a result is stalled
// the t quotient comes from a 32-stage restoring divider, one quotient bit per stage
// reset: arst_n clears all valid bits and loads the default disc
// (center at origin, normal +z, radius 1.0)
// ----------------------------------------------------------------------------
// ray_disc_intersection
// pipelined ray / disc hit test in signed Q16.16
// ----------------------------------------------------------------------------
`default_nettype none

module ray_disc_intersection (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [rdi_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [rdi_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire rdi_pkg::in_item_t                   in_item,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output rdi_pkg::out_item_t                       out_item
);

	localparam int N = rdi_pkg::DIV_STEPS;

	function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
		if (v > 49'sd2147483647) begin
			return 32'sh7fff_ffff;
		end else if (v < -49'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	// configuration
	logic signed [31:0] cx_q, cy_q, cz_q;
	logic signed [17:0] nx_q, ny_q, nz_q;
	logic [30:0] rad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
			cz_q <= '0;
			nx_q <= '0;
			ny_q <= '0;
			nz_q <= 18'sd65536;
			rad_q <= 31'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				rdi_pkg::CFG_CENTER_X: cx_q <= cfg_data;
				rdi_pkg::CFG_CENTER_Y: cy_q <= cfg_data;
				rdi_pkg::CFG_CENTER_Z: cz_q <= cfg_data;
				rdi_pkg::CFG_NORMAL_X: nx_q <= cfg_data[17:0];
				rdi_pkg::CFG_NORMAL_Y: ny_q <= cfg_data[17:0];
				rdi_pkg::CFG_NORMAL_Z: nz_q <= cfg_data[17:0];
				rdi_pkg::CFG_RADIUS:   rad_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	logic en;

	// valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;
	logic v_sd [0:N];

	assign en = !v_s12 || out_ready;
	assign in_ready = en;
	assign out_valid = v_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			for (int k = 0; k <= N; k++) begin
				v_sd[k] <= 1'b0;
			end
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_sd[0] <= v_s4;
			for (int k = 0; k < N; k++) begin
				v_sd[k+1] <= v_sd[k];
			end
			v_s6 <= v_sd[N];
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
		end
	end

	// front end: dot products
	rdi_pkg::in_item_t ray_s1, ray_s2, ray_s3, ray_s4;
	logic signed [32:0] dfx_s1, dfy_s1, dfz_s1;
	logic signed [50:0] pnx_s2, pny_s2, pnz_s2;
	logic signed [49:0] pdx_s2, pdy_s2, pdz_s2;
	logic signed [52:0] num_s3;
	logic signed [51:0] den_s3;
	logic [52:0] un_s4;
	logic [51:0] ud_s4;
	logic neg_s4, dz_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s1 <= in_item;
			dfx_s1 <= 33'(cx_q) - 33'(in_item.origin_x);
			dfy_s1 <= 33'(cy_q) - 33'(in_item.origin_y);
			dfz_s1 <= 33'(cz_q) - 33'(in_item.origin_z);

			ray_s2 <= ray_s1;
			pnx_s2 <= dfx_s1 * nx_q;
			pny_s2 <= dfy_s1 * ny_q;
			pnz_s2 <= dfz_s1 * nz_q;
			pdx_s2 <= $signed(ray_s1.dir_x) * nx_q;
			pdy_s2 <= $signed(ray_s1.dir_y) * ny_q;
			pdz_s2 <= $signed(ray_s1.dir_z) * nz_q;

			ray_s3 <= ray_s2;
			num_s3 <= 53'(pnx_s2) + 53'(pny_s2) + 53'(pnz_s2);
			den_s3 <= 52'(pdx_s2) + 52'(pdy_s2) + 52'(pdz_s2);

			ray_s4 <= ray_s3;
			un_s4 <= num_s3[52] ? 53'(-num_s3) : 53'(num_s3);
			ud_s4 <= den_s3[51] ? 52'(-den_s3) : 52'(den_s3);
			neg_s4 <= num_s3[52] ^ den_s3[51];
			dz_s4 <= (den_s3 == '0);
		end
	end

	// divider: t = floor(|num| * 2^16 / |den|), one bit per stage
	rdi_pkg::in_item_t ray_sd [0:N];
	logic [51:0] rem_sd [0:N];
	logic [51:0] ud_sd [0:N];
	logic [31:0] q_sd [0:N];
	logic [15:0] lo_sd [0:N];
	logic neg_sd [0:N];
	logic bad_sd [0:N];
	logic [52:0] div_sh [0:N-1];
	logic div_ge [0:N-1];

	always_comb begin
		for (int k = 0; k < N; k++) begin
			div_sh[k] = {rem_sd[k], lo_sd[k][15]};
			div_ge[k] = div_sh[k] >= {1'b0, ud_sd[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ray_sd[0] <= ray_s4;
			rem_sd[0] <= 52'(un_s4[52:16]);
			ud_sd[0] <= ud_s4;
			q_sd[0] <= '0;
			lo_sd[0] <= un_s4[15:0];
			neg_sd[0] <= neg_s4;
			bad_sd[0] <= dz_s4 || ({16'd0, un_s4[52:16]} >= {1'b0, ud_s4});
			for (int k = 0; k < N; k++) begin
				ray_sd[k+1] <= ray_sd[k];
				rem_sd[k+1] <= div_ge[k] ? 52'(div_sh[k] - {1'b0, ud_sd[k]})
					: div_sh[k][51:0];
				ud_sd[k+1] <= ud_sd[k];
				q_sd[k+1] <= {q_sd[k][30:0], div_ge[k]};
				lo_sd[k+1] <= {lo_sd[k][14:0], 1'b0};
				neg_sd[k+1] <= neg_sd[k];
				bad_sd[k+1] <= bad_sd[k];
			end
		end
	end

	// back end: range test, hit point, distance test
	rdi_pkg::in_item_t ray_s6, ray_s7;
	logic signed [31:0] t_s6, t_s7, t_s8, t_s9, t_s10, t_s11;
	logic ok_s6, ok_s7, ok_s8, ok_s9, ok_s10, ok_s11;
	logic signed [63:0] prx_s7, pry_s7, prz_s7;
	logic signed [48:0] px_s8, py_s8, pz_s8;
	logic signed [49:0] ex_s9, ey_s9, ez_s9;
	logic signed [31:0] hx_s9, hy_s9, hz_s9, hx_s10, hy_s10, hz_s10, hx_s11, hy_s11, hz_s11;
	logic [49:0] mx_s10, my_s10, mz_s10;
	logic [61:0] sqx_s11, sqy_s11, sqz_s11, r2_s11;
	logic far_s11;
	rdi_pkg::out_item_t out_s12;
	logic [31:0] qf;
	logic [63:0] dist2;

	assign qf = q_sd[N];
	assign dist2 = 64'(sqx_s11) + 64'(sqy_s11) + 64'(sqz_s11);

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s6 <= ray_sd[N];
			t_s6 <= neg_sd[N] ? 32'(-qf) : qf;
			ok_s6 <= !bad_sd[N] && (neg_sd[N] ? (qf <= 32'h8000_0000) : !qf[31]);

			ray_s7 <= ray_s6;
			t_s7 <= t_s6;
			ok_s7 <= ok_s6 && (t_s6 >= $signed(ray_s6.t_low))
				&& (t_s6 <= $signed(ray_s6.t_high));
			prx_s7 <= t_s6 * $signed(ray_s6.dir_x);
			pry_s7 <= t_s6 * $signed(ray_s6.dir_y);
			prz_s7 <= t_s6 * $signed(ray_s6.dir_z);

			t_s8 <= t_s7;
			ok_s8 <= ok_s7;
			px_s8 <= 49'($signed(ray_s7.origin_x)) + 49'(prx_s7 >>> 16);
			py_s8 <= 49'($signed(ray_s7.origin_y)) + 49'(pry_s7 >>> 16);
			pz_s8 <= 49'($signed(ray_s7.origin_z)) + 49'(prz_s7 >>> 16);

			t_s9 <= t_s8;
			ok_s9 <= ok_s8;
			ex_s9 <= 50'(px_s8) - 50'(cx_q);
			ey_s9 <= 50'(py_s8) - 50'(cy_q);
			ez_s9 <= 50'(pz_s8) - 50'(cz_q);
			hx_s9 <= sat32(px_s8);
			hy_s9 <= sat32(py_s8);
			hz_s9 <= sat32(pz_s8);

			t_s10 <= t_s9;
			ok_s10 <= ok_s9;
			mx_s10 <= ex_s9[49] ? 50'(-ex_s9) : 50'(ex_s9);
			my_s10 <= ey_s9[49] ? 50'(-ey_s9) : 50'(ey_s9);
			mz_s10 <= ez_s9[49] ? 50'(-ez_s9) : 50'(ez_s9);
			hx_s10 <= hx_s9;
			hy_s10 <= hy_s9;
			hz_s10 <= hz_s9;

			t_s11 <= t_s10;
			ok_s11 <= ok_s10;
			far_s11 <= (mx_s10 > 50'(rad_q)) || (my_s10 > 50'(rad_q))
				|| (mz_s10 > 50'(rad_q));
			sqx_s11 <= mx_s10[30:0] * mx_s10[30:0];
			sqy_s11 <= my_s10[30:0] * my_s10[30:0];
			sqz_s11 <= mz_s10[30:0] * mz_s10[30:0];
			r2_s11 <= rad_q * rad_q;
			hx_s11 <= hx_s10;
			hy_s11 <= hy_s10;
			hz_s11 <= hz_s10;

			if (ok_s11 && !far_s11 && (dist2 <= 64'(r2_s11))) begin
				out_s12.hit <= 1'b1;
				out_s12.hit_t <= t_s11;
				out_s12.hit_x <= hx_s11;
				out_s12.hit_y <= hy_s11;
				out_s12.hit_z <= hz_s11;
			end else begin
				out_s12 <= '0;
			end
		end
	end

	assign out_item = out_s12;

endmodule

`default_nettype wire

### hw/rtl/rdi_checker.sv
// ----------------------------------------------------------------------------
// rdi_checker
// port-level checks of the ray / disc intersection pipeline
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rdi_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire rdi_pkg::out_item_t out_item
);

	`RDI_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped")
	`RDI_ASSERT_NXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_item), "result changed while stalled")
	`RDI_ASSERT_IMP(a_miss_zero, clk, arst_n, out_valid && !out_item.hit, out_item.hit_t == '0 && out_item.hit_x == '0 && out_item.hit_y == '0 && out_item.hit_z == '0, "miss carries nonzero fields")
	`RDI_ASSERT_IMP(a_stall_blocks, clk, arst_n, out_valid && !out_ready, !in_ready, "transaction taken during stall")

endmodule

bind ray_disc_intersection rdi_checker u_rdi_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_item(out_item)
);

`default_nettype wire
